// File: rtl/wbss_pkg.sv
// Shared types and constants of the wildcard byte signature scanner.
package wbss_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int FILL_W      = $clog2(MAX_PATTERN + 1);
  localparam int POS_W       = $clog2(MAX_PATTERN);
  localparam int ADDR_W      = 64;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CARE_W      = 16;
  localparam int LEN_W       = 5;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CARE_MASK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_BASE    = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } wbss_in_t;

  typedef struct packed {
    logic              found;
    logic [ADDR_W-1:0] match_address;
  } wbss_out_t;

endpackage

// File: rtl/wildcard_byte_signature_scanner_unit.sv
// Wildcard byte signature scanner: streaming window compare with result register.
//
// Bytes of a memory region enter on the in_* channel (valid/ready), one beat
// per byte in address order, with last_byte set on the final byte. A result
// beat leaves on the out_* channel: found=1 with the start address of the
// first match, or found=0 and address 0 when the region ends unmatched.
// At most one result is produced per region.
// Registers are written through cfg_we/cfg_index/cfg_data; the user is to write them only
// while idle, which the block does not enforce: 0 pattern bytes 0..7, 1 pattern bytes 8..15,
// 2 care mask, 3 pattern length, 4 scan base. Unknown indexes are ignored.
// Throughput: one byte per cycle. The window shift, the 16-position masked
// compare and the start-address subtract all settle in the cycle a byte is
// accepted, and the result is loaded into the output register at the edge
// that accepts the byte that caused it. The input keeps flowing while a
// result waits, as long as the next byte causes no result of its own; such
// a byte waits until the held result is taken.
// Reset (rst, synchronous) clears the configuration registers, out_valid, the window and the
// region state (out_data is not cleared); there is no clearing pass.
module wildcard_byte_signature_scanner_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [wbss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wbss_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  wbss_pkg::wbss_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output wbss_pkg::wbss_out_t               out_data
);
  import wbss_pkg::*;

  logic [63:0]        pattern_low;
  logic [63:0]        pattern_high;
  logic [CARE_W-1:0]  care_mask;
  logic [LEN_W-1:0]   pattern_length;
  logic [ADDR_W-1:0]  scan_base;

  logic [7:0]         byte_window [MAX_PATTERN];
  logic [FILL_W-1:0]  fill_count;
  logic [ADDR_W-1:0]  current_address;
  logic               match_reported;

  logic [7:0]         window_next [MAX_PATTERN];
  logic [FILL_W-1:0]  fill_next;
  logic [FILL_W-1:0]  len;
  logic [ADDR_W-1:0]  addr_now;
  logic [ADDR_W-1:0]  addr_start;
  logic [MAX_PATTERN-1:0] pos_ok;
  logic               emit_match;
  logic               emit;
  logic               in_fire;
  wbss_out_t          result;

  // Configuration decode
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      care_mask      <= '0;
      pattern_length <= '0;
      scan_base      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:  pattern_low    <= cfg_data;
        REG_PATTERN_HIGH: pattern_high   <= cfg_data;
        REG_CARE_MASK:    care_mask      <= cfg_data[CARE_W-1:0];
        REG_PATTERN_LEN:  pattern_length <= cfg_data[LEN_W-1:0];
        REG_SCAN_BASE:    scan_base      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the length to the window depth
  always_comb begin
    if (pattern_length > LEN_W'(MAX_PATTERN)) begin
      len = FILL_W'(MAX_PATTERN);
    end else begin
      len = FILL_W'(pattern_length);
    end
  end

  always_comb begin
    window_next[0] = in_data.data_byte;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      window_next[k] = byte_window[k-1];
    end
    if (fill_count < FILL_W'(MAX_PATTERN)) begin
      fill_next = fill_count + FILL_W'(1);
    end else begin
      fill_next = fill_count;
    end
  end

  // Position i of the pattern lines up with window entry len-1-i
  always_comb begin
    logic [FILL_W-1:0] tap;
    logic [7:0]        pat;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      tap = len - FILL_W'(1) - FILL_W'(i);
      if (i < 8) begin
        pat = pattern_low[8*(i%8) +: 8];
      end else begin
        pat = pattern_high[8*(i%8) +: 8];
      end
      pos_ok[i] = (FILL_W'(i) >= len) || (i >= CARE_W) || !care_mask[i % CARE_W]
                  || (window_next[tap[POS_W-1:0]] == pat);
    end
  end

  always_comb begin
    addr_now = (fill_count == '0) ? scan_base : current_address;
    if (len == '0) begin
      addr_start = addr_now;
    end else begin
      addr_start = addr_now - ADDR_W'(len - FILL_W'(1));
    end
    emit_match = !match_reported && (fill_next >= len) && (&pos_ok);
    emit       = emit_match || (in_data.last_byte && !match_reported);
    result.found         = emit_match;
    result.match_address = emit_match ? addr_start : '0;
  end

  // Hold a byte that would produce a result while the output slot is occupied
  assign in_ready = !out_valid || out_ready || !emit;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count      <= '0;
      current_address <= '0;
      match_reported  <= 1'b0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        byte_window[k] <= '0;
      end
    end else if (in_fire) begin
      if (in_data.last_byte) begin
        fill_count     <= '0;
        match_reported <= 1'b0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
          byte_window[k] <= '0;
        end
      end else begin
        fill_count      <= fill_next;
        current_address <= addr_now + ADDR_W'(1);
        match_reported  <= match_reported || emit_match;
        for (int k = 0; k < MAX_PATTERN; k++) begin
          byte_window[k] <= window_next[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_data <= result;
    end
  end

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.found |-> out_data.match_address == '0)
    else $error("not-found result carries a nonzero address");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(MAX_PATTERN))
    else $error("fill count above window depth");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_data.last_byte |=> fill_count == '0 && !match_reported)
    else $error("region state not cleared after last byte");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    in_fire && match_reported |-> !emit)
    else $error("second result in one region");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && in_fire |-> !emit)
    else $error("pending result overwritten");

endmodule

// File: tb/sv/tb.sv
// Self-checking bench for the wildcard byte signature scanner: directed rows, then random regions.
`timescale 1ns / 1ps

module tb;
  import wbss_pkg::*;

  localparam int IDLE_PCT       = 31;
  localparam int RANDOM_ITEMS   = 500;
  localparam int CALM_FROM      = 200;
  localparam int CALM_TO        = 330;
  localparam int SETTLE_CYCLES  = 3;
  localparam int WATCHDOG_LIMIT = 2000;

  // One row of stimulus: a register write or a byte, optionally with a typed-in result.
  typedef struct packed {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     value;
    logic                 last;
    logic                 typed;
    logic                 found;
    logic [ADDR_W-1:0]    addr;
  } stim_row_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  wbss_in_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  wbss_out_t            out_data;

  wildcard_byte_signature_scanner_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Register shadows, at their reset values.
  logic [63:0]       pat_lo    = '0;
  logic [63:0]       pat_hi    = '0;
  logic [CARE_W-1:0] care      = '0;
  logic [LEN_W-1:0]  pat_len   = '0;
  logic [ADDR_W-1:0] scan_base = '0;

  // Scanner state, cleared as after reset.
  logic [7:0]        win_bytes [MAX_PATTERN] = '{default: '0};
  int                seen;
  logic [ADDR_W-1:0] cur_addr = '0;
  bit                hit_done;

  stim_row_t plan [$];
  wbss_out_t pending_results [$];

  bit        cfg_open;
  bit        calm;
  bit        cur_typed;
  wbss_out_t cur_expect;
  int        items_sent;
  int        regions;
  int        results_seen;
  int        hits;
  int        settings;
  int        mismatches;
  int        quiet;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= !rst && (calm || $urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic logic [7:0] pattern_byte(int i);
    if (i < 8) return pat_lo[8*i +: 8];
    return pat_hi[8*(i-8) +: 8];
  endfunction

  // Shift one byte into the window and work out the result it causes, if any.
  task automatic next_scan_result(input logic [7:0] b, input logic last, output bit emits,
                                  output wbss_out_t res);
    int  span;
    bit  ok;
    emits = 1'b0;
    res   = '0;
    span  = (pat_len > MAX_PATTERN) ? MAX_PATTERN : int'(pat_len);
    if (seen == 0) cur_addr = scan_base;
    for (int k = MAX_PATTERN - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
    win_bytes[0] = b;
    if (seen < MAX_PATTERN) seen++;
    if (!hit_done && seen >= span) begin
      ok = 1'b1;
      for (int i = 0; i < span; i++) begin
        if (i < CARE_W && care[i] && win_bytes[span-1-i] != pattern_byte(i)) ok = 1'b0;
      end
      if (ok) begin
        emits               = 1'b1;
        res.found           = 1'b1;
        res.match_address   = (span > 0) ? cur_addr - ADDR_W'(span - 1) : cur_addr;
        hit_done            = 1'b1;
      end
    end
    if (last) begin
      if (!hit_done) begin
        emits = 1'b1;
        res   = '0;
      end
      for (int k = 0; k < MAX_PATTERN; k++) win_bytes[k] = '0;
      seen     = 0;
      hit_done = 1'b0;
    end else begin
      cur_addr = cur_addr + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    bit        emits;
    wbss_out_t want;
    wbss_out_t got;
    if (!rst) begin
      if (out_valid && out_ready) begin
        got = out_data;
        if (pending_results.size() == 0) begin
          $error("result with nothing pending: found=%0b match_address=%h",
                 got.found, got.match_address);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.found !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, got.found);
            mismatches++;
          end
          if (got.match_address !== want.match_address) begin
            $error("match_address: expected %h, got %h", want.match_address,
                   got.match_address);
            mismatches++;
          end
          results_seen++;
          if (want.found) hits++;
        end
      end
      if (in_valid && in_ready) begin
        next_scan_result(in_data.data_byte, in_data.last_byte, emits, want);
        if (cur_typed) begin
          emits = 1'b1;
          want  = cur_expect;
        end
        if (emits) pending_results.push_back(want);
        if (in_data.last_byte) regions++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
    stim_row_t r;
    r        = '0;
    r.is_reg = 1'b1;
    r.idx    = idx;
    r.value  = v;
    plan.push_back(r);
  endfunction

  function automatic void add_byte(logic [7:0] b, logic last);
    stim_row_t r;
    r       = '0;
    r.value = CFG_W'(b);
    r.last  = last;
    plan.push_back(r);
  endfunction

  function automatic void add_byte_chk(logic [7:0] b, logic last, logic found,
                                       logic [ADDR_W-1:0] addr);
    stim_row_t r;
    r       = '0;
    r.value = CFG_W'(b);
    r.last  = last;
    r.typed = 1'b1;
    r.found = found;
    r.addr  = addr;
    plan.push_back(r);
  endfunction

  // Drop valid and wait out every pending result plus the pipeline tail.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic put_byte(input stim_row_t r);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
    in_valid          <= 1'b1;
    in_data.data_byte <= r.value[7:0];
    in_data.last_byte <= r.last;
    cur_typed                = r.typed;
    cur_expect.found         = r.found;
    cur_expect.match_address = r.addr;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
    calm = (items_sent >= CALM_FROM && items_sent < CALM_TO);
  endtask

  task automatic run_rows();
    stim_row_t r;
    while (plan.size() != 0) begin
      r = plan.pop_front();
      if (r.is_reg) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
        end
        cfg_we    <= 1'b1;
        cfg_index <= r.idx;
        cfg_data  <= r.value;
        case (r.idx)
          REG_PATTERN_LOW:  pat_lo    = r.value;
          REG_PATTERN_HIGH: pat_hi    = r.value;
          REG_CARE_MASK:    care      = r.value[CARE_W-1:0];
          REG_PATTERN_LEN:  pat_len   = r.value[LEN_W-1:0];
          REG_SCAN_BASE:    scan_base = r.value;
          default: ;
        endcase
        @(negedge clk);
      end else begin
        if (cfg_open) begin
          cfg_we   <= 1'b0;
          cfg_open = 1'b0;
        end
        put_byte(r);
      end
    end
  endtask

  // One random register setting followed by a few regions, most with the pattern planted.
  task automatic plan_phase();
    logic [63:0]       lo;
    logic [63:0]       hi;
    logic [ADDR_W-1:0] base_v;
    logic [CARE_W-1:0] mask;
    logic [LEN_W-1:0]  len_v;
    logic [7:0]        pat [MAX_PATTERN];
    logic [7:0]        region [$];
    int                span;
    int                rlen;
    int                at;
    int                cut;
    int                pick;
    lo   = {$urandom, $urandom};
    hi   = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick == 0) mask = '1;
    else if (pick == 1) mask = '0;
    else if (pick < 5) mask = CARE_W'($urandom);
    else mask = CARE_W'($urandom | $urandom);
    pick = $urandom_range(0, 19);
    if (pick == 0) len_v = '0;
    else if (pick == 1) len_v = LEN_W'(MAX_PATTERN);
    else if (pick == 2) len_v = LEN_W'($urandom_range(MAX_PATTERN + 1, 31));
    else if (pick < 6) len_v = LEN_W'($urandom_range(9, MAX_PATTERN - 1));
    else len_v = LEN_W'($urandom_range(1, 8));
    pick = $urandom_range(0, 5);
    if (pick == 0) base_v = '1 - ADDR_W'($urandom_range(0, 20));
    else if (pick == 1) base_v = '0;
    else base_v = {$urandom, $urandom};
    for (int i = 0; i < MAX_PATTERN; i++) pat[i] = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
    span = (len_v > MAX_PATTERN) ? MAX_PATTERN : int'(len_v);

    add_reg(REG_PATTERN_LOW, lo);
    add_reg(REG_PATTERN_HIGH, hi);
    add_reg(REG_CARE_MASK, CFG_W'(mask));
    add_reg(REG_PATTERN_LEN, CFG_W'(len_v));
    add_reg(REG_SCAN_BASE, base_v);

    repeat ($urandom_range(2, 6)) begin
      rlen = $urandom_range(1, span + 12);
      region.delete();
      // sprinkle pattern bytes so partial matches show up
      for (int i = 0; i < rlen; i++) begin
        if ($urandom_range(0, 3) == 0)
          region.push_back(pat[$urandom_range(0, span > 0 ? span - 1 : 0)]);
        else
          region.push_back(8'($urandom));
      end
      pick = $urandom_range(0, 99);
      if (pick < 60 && span > 0 && rlen >= span) begin
        at = $urandom_range(0, rlen - span);
        for (int i = 0; i < span; i++) if (mask[i]) region[at+i] = pat[i];
      end else if (pick < 75 && span > 1) begin
        // head of the pattern runs into the region end
        cut = $urandom_range(1, span - 1);
        if (cut > rlen) cut = rlen;
        for (int i = 0; i < cut; i++) if (mask[i]) region[rlen-cut+i] = pat[i];
      end
      for (int i = 0; i < rlen; i++) add_byte(region[i], i == rlen - 1);
    end
    // sometimes leave the region open across the next register setting
    if ($urandom_range(0, 4) == 0) plan[plan.size()-1].last = 1'b0;
    settings++;
  endtask

  initial begin
    int directed_items;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // reset state: empty pattern matches at the first byte, the rest of the region is silent
    add_byte_chk(8'h00, 1'b0, 1'b1, '0);
    add_byte(8'hFF, 1'b1);

    // four positions, wildcards at 1 and 3, base just below the wrap
    add_reg(REG_PATTERN_LOW, 64'h0000_0000_00FF_00AB);
    add_reg(REG_CARE_MASK, 64'h0005);
    add_reg(REG_PATTERN_LEN, 64'd4);
    add_reg(REG_SCAN_BASE, 64'hFFFF_FFFF_FFFF_FFFE);
    // region ends before the trailing wildcard arrives
    add_byte(8'hAB, 1'b0);
    add_byte(8'h12, 1'b0);
    add_byte_chk(8'hFF, 1'b1, 1'b0, '0);
    // trailing wildcard completes on the last byte
    add_byte(8'hAB, 1'b0);
    add_byte(8'h12, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte_chk(8'h77, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFE);

    // settings change mid-region; the new base holds off until the next region
    add_byte(8'hAB, 1'b0);
    add_reg(REG_PATTERN_LEN, 64'd1);
    add_reg(REG_CARE_MASK, 64'h0001);
    add_reg(REG_SCAN_BASE, 64'h10);
    add_byte(8'hAB, 1'b1);
    add_byte_chk(8'hAB, 1'b1, 1'b1, 64'h10);

    // full width, every position cared, overlong length clamps to the window
    add_reg(REG_PATTERN_LOW, '1);
    add_reg(REG_PATTERN_HIGH, '0);
    add_reg(REG_CARE_MASK, 64'hFFFF);
    add_reg(REG_PATTERN_LEN, 64'd31);
    add_reg(REG_SCAN_BASE, '0);
    for (int u = int'(REG_SCAN_BASE) + 1; u < (1 << CFG_IDX_W); u++)
      add_reg(CFG_IDX_W'(u), '1);
    for (int i = 0; i < MAX_PATTERN - 1; i++) add_byte(i < 8 ? 8'hFF : 8'h00, 1'b0);
    add_byte_chk(8'h00, 1'b1, 1'b1, '0);
    run_rows();

    directed_items = items_sent;
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      plan_phase();
      run_rows();
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES + 1) @(negedge clk);

    $display("scanned %0d bytes in %0d closed regions under %0d random settings",
             items_sent, regions, settings);
    $display("checked %0d results: %0d matches, %0d regions without one",
             results_seen, hits, results_seen - hits);
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
